[sv/htbd_pkg.sv]
// Shared widths and codes of the Huffman tree-walk bit decoder.
package htbd_pkg;

	localparam int IDX_W = 8;
	localparam int WORD_W = 16;
	localparam int BYTE_W = 8;
	localparam int OP_W = 2;
	localparam int KIND_W = 2;
	localparam int SKIP_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int NODE_ENTRIES_DEF = 256;

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = 3;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_START = 2'd1;
	localparam logic [OP_W-1:0] OP_DATA = 2'd2;

	localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START_OK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_START_REJ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROOT_INDEX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEAF_MARKER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_STRINGS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STRING_COUNT = 2'd3;

	localparam logic [IDX_W-1:0] ROOT_RESET = 8'd0;
	localparam logic [IDX_W-1:0] LEAF_RESET = 8'd255;
	localparam logic [SKIP_W-1:0] COUNT_RESET = 16'd1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] symbol;
		logic eos;
	} result_t;

endpackage

[sv/huffman_tree_bit_decoder_unit.sv]
// Huffman tree-walk decoder: node table, bit-serial walk and result output.
// A load item writes one node table entry. A start item gives one result. A data
// byte is shifted out most significant bit first, one code bit per cycle while no
// result waits for the output register, because each bit needs the table word of
// the node reached by the previous bit, and the table has a registered read port.
// A byte goes from acceptance to the next acceptance through these steps: the
// current node is fetched, eight bit steps follow, the last child is tested, and the
// final result, if any, is handed over. A start and a byte also lose every cycle in
// which a result waits for the output register to drain. A second read port keeps
// the root node word at hand, so a leaf returns the walk to the root at no cost.
// Reading a table entry that was never loaded gives an undefined result.
module huffman_tree_bit_decoder_unit
	import htbd_pkg::*;
#(
	parameter int NODE_ENTRIES = NODE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// node_addr[7:0], node_word[23:8], data_byte[31:24]
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// op[1:0]
	input  logic [S_TUSER_W-1:0] s_axis_tuser,

	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// symbol[7:0]
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// kind[1:0], end_of_string[2]
	output logic [M_TUSER_W-1:0] m_axis_tuser,
	output logic m_axis_tlast,

	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;
	localparam logic [IDX_W:0] NE = (IDX_W+1)'(NODE_ENTRIES);
	localparam logic [3:0] LAST_STEP = 4'(BYTE_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [WORD_W-1:0] mem [NODE_ENTRIES];

	logic [1:0] st_q;
	logic [3:0] cnt_q;
	logic [BYTE_W-1:0] byte_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] nxt_q;
	logic [SKIP_W-1:0] skip_q;

	logic [IDX_W-1:0] root_q;
	logic [IDX_W-1:0] leaf_q;
	logic [SKIP_W-1:0] skip_cfg_q;
	logic [SKIP_W-1:0] count_q;

	logic [WORD_W-1:0] rd_q;
	logic rd_ok_q;
	logic [WORD_W-1:0] root_rd_q;
	logic root_ok_q;

	logic pend_v_q;
	result_t pend_q;
	logic out_v_q;
	result_t out_q;
	logic out_last_q;

	logic [OP_W-1:0] in_op;
	logic [IDX_W-1:0] in_addr;
	logic [WORD_W-1:0] in_word;
	logic [BYTE_W-1:0] in_byte;
	logic acc;

	logic [WORD_W-1:0] rd_word;
	logic [WORD_W-1:0] root_word;
	logic [WORD_W-1:0] cur_word;
	logic [IDX_W-1:0] cur_idx;
	logic [IDX_W-1:0] child;
	logic [IDX_W-1:0] rd_addr;
	logic rd_en;
	logic first;
	logic leaf_hit;
	logic emit;
	logic out_free;
	logic stall;
	logic adv;
	logic push_walk;
	logic push_flush;
	logic start_ok;
	result_t new_res;

	assign in_op = s_axis_tuser[1:0];
	assign in_addr = s_axis_tdata[7:0];
	assign in_word = s_axis_tdata[23:8];
	assign in_byte = s_axis_tdata[31:24];

	assign s_axis_tready = (st_q == ST_IDLE);
	assign acc = s_axis_tvalid && s_axis_tready;

	// Entries beyond the table read as zero.
	assign rd_word = rd_ok_q ? rd_q : '0;
	assign root_word = root_ok_q ? root_rd_q : '0;

	assign first = (cnt_q == 4'd0);
	assign leaf_hit = !first && (rd_word[7:0] == leaf_q);
	assign emit = leaf_hit && (skip_q == '0);
	assign out_free = !out_v_q || m_axis_tready;
	// A new result needs the pending slot moved to the output register first.
	assign stall = emit && pend_v_q && !out_free;
	assign adv = (st_q == ST_WALK) && !stall;

	assign cur_word = leaf_hit ? root_word : rd_word;
	assign cur_idx = first ? cur_q : (leaf_hit ? root_q : nxt_q);
	assign child = byte_q[BYTE_W-1] ? cur_word[15:8] : cur_word[7:0];

	assign rd_addr = (st_q == ST_WALK) ? child : cur_q;
	assign rd_en = (st_q == ST_IDLE) || (adv && (cnt_q != LAST_STEP));

	assign push_walk = adv && emit && pend_v_q;
	assign push_flush = (st_q == ST_FLUSH) && pend_v_q && out_free;

	assign start_ok = (skip_cfg_q == '0) || (skip_cfg_q < count_q);

	assign new_res.kind = KIND_SYMBOL;
	assign new_res.symbol = rd_word[15:8];
	assign new_res.eos = (rd_word[15:8] == '0);

	// Node table with one write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (acc && (in_op == OP_LOAD) && ({1'b0, in_addr} < NE)) begin
			mem[in_addr[AW-1:0]] <= in_word;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr[AW-1:0]];
			rd_ok_q <= ({1'b0, rd_addr} < NE);
		end
		root_rd_q <= mem[root_q[AW-1:0]];
		root_ok_q <= ({1'b0, root_q} < NE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= ROOT_RESET;
			leaf_q <= LEAF_RESET;
			skip_cfg_q <= '0;
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROOT_INDEX: root_q <= cfg_data[IDX_W-1:0];
				REG_LEAF_MARKER: leaf_q <= cfg_data[IDX_W-1:0];
				REG_SKIP_STRINGS: skip_cfg_q <= cfg_data[SKIP_W-1:0];
				REG_STRING_COUNT: count_q <= cfg_data[SKIP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			byte_q <= '0;
			cur_q <= ROOT_RESET;
			nxt_q <= '0;
			skip_q <= '0;
			pend_v_q <= 1'b0;
			pend_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (acc && (in_op == OP_START)) begin
						cur_q <= root_q;
						skip_q <= start_ok ? skip_cfg_q : '0;
						pend_v_q <= 1'b1;
						pend_q.kind <= start_ok ? KIND_START_OK : KIND_START_REJ;
						pend_q.symbol <= '0;
						pend_q.eos <= 1'b0;
						st_q <= ST_FLUSH;
					end else if (acc && (in_op == OP_DATA)) begin
						byte_q <= in_byte;
						cnt_q <= '0;
						st_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (adv) begin
						cur_q <= cur_idx;
						nxt_q <= child;
						byte_q <= {byte_q[BYTE_W-2:0], 1'b0};
						cnt_q <= cnt_q + 4'd1;
						if (emit) begin
							pend_v_q <= 1'b1;
							pend_q <= new_res;
						end else if (leaf_hit && (rd_word[15:8] == '0)) begin
							skip_q <= skip_q - 1'b1;
						end
						if (cnt_q == LAST_STEP) begin
							st_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (push_flush) begin
						pend_v_q <= 1'b0;
						st_q <= ST_IDLE;
					end else if (!pend_v_q) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Output register; only the final result of an item carries tlast.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push_walk || push_flush) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_walk || push_flush) begin
			out_q <= pend_q;
			out_last_q <= push_flush;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_q.symbol;
	assign m_axis_tuser = {out_q.eos, out_q.kind};
	assign m_axis_tlast = out_last_q;

`ifndef SYNTH
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !pend_v_q)
		else $error("pending result left behind at idle");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WALK) |-> (cnt_q <= LAST_STEP))
		else $error("bit step count out of range");

	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (in_op == OP_START)) |=> ((st_q == ST_FLUSH) && pend_v_q))
		else $error("start item did not queue its result");

	a_start_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (out_q.kind != KIND_SYMBOL)) |-> m_axis_tlast)
		else $error("start result not marked last");
`endif

endmodule
